[rtl/core/fsla_pkg.sv]
package fsla_pkg;

  localparam int INDEX_W    = 10;
  localparam int CAP_W      = 11;
  localparam int LINES_W    = 7;
  localparam int OFFSET_W   = 22;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CAP_W-1:0]   CAP_RESET   = 11'd1024;
  localparam logic [LINES_W-1:0] LINES_RESET = 7'd1;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LINES = 1'b1;

  typedef enum logic [1:0] {
    ST_GRANTED = 2'd0,
    ST_FULL    = 2'd1,
    ST_FREED   = 2'd2,
    ST_BAD     = 2'd3
  } status_t;

  // One chain link: the empty flag marks the end of the free chain.
  typedef struct packed {
    logic               empty;
    logic [INDEX_W-1:0] idx;
  } link_t;

  typedef struct packed {
    status_t            status;
    logic [INDEX_W-1:0] index;
  } result_t;

  typedef struct packed {
    logic             pop_pending;
    logic [CAP_W-1:0] fresh_count;
  } core_status_t;

endpackage

[rtl/core/fsla_if.sv]
interface fsla_in_if;
  import fsla_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [INDEX_W-1:0] slot_index;

  modport source (output valid, output kind, output slot_index, input ready);
  modport sink   (input valid, input kind, input slot_index, output ready);
endinterface

interface fsla_out_if;
  import fsla_pkg::*;

  logic                valid;
  logic                ready;
  status_t             status;
  logic [INDEX_W-1:0]  granted_index;
  logic [OFFSET_W-1:0] byte_offset;

  modport source (output valid, output status, output granted_index, output byte_offset,
                  input ready);
  modport sink   (input valid, input status, input granted_index, input byte_offset,
                  output ready);
endinterface

[rtl/core/fsla_link_mem.sv]
module fsla_link_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  fsla_pkg::link_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output fsla_pkg::link_t rdata_r
);
  import fsla_pkg::*;

  link_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

[rtl/core/fsla_alloc_core.sv]
module fsla_alloc_core #(
  parameter int SLOTS = 1024,
  localparam int DEPTH = (SLOTS < 1024) ? SLOTS : 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic                                kind,
  input  logic [fsla_pkg::INDEX_W-1:0]        slot_index,
  input  logic [fsla_pkg::CAP_W-1:0]          capacity,
  input  fsla_pkg::link_t                     rd_data,
  output logic                                mem_we,
  output logic [AW-1:0]                       mem_waddr,
  output fsla_pkg::link_t                     mem_wdata,
  output logic                                mem_re,
  output logic [AW-1:0]                       mem_raddr,
  output fsla_pkg::result_t                   result,
  output fsla_pkg::core_status_t              status
);
  import fsla_pkg::*;

  localparam logic [CAP_W-1:0] SLOTS_CAP = CAP_W'(DEPTH);

  link_t            head_r, head_nxt, head_eff;
  logic [CAP_W-1:0] fresh_r, fresh_nxt, cap_eff;
  logic             pend_r, pend_nxt;

  // After a pop, the new chain head arrives from the link store's read register in the following cycle.
  assign head_eff = pend_r ? rd_data : head_r;
  assign cap_eff  = (capacity > SLOTS_CAP) ? SLOTS_CAP : capacity;

  assign mem_raddr = head_eff.idx[AW-1:0];
  assign mem_waddr = slot_index[AW-1:0];
  assign mem_wdata = head_eff;

  always_comb begin
    head_nxt  = head_eff;
    fresh_nxt = fresh_r;
    pend_nxt  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    result    = '{status: ST_FULL, index: '0};
    if (accept) begin
      if (kind == KIND_ALLOC) begin
        if (!head_eff.empty) begin
          result   = '{status: ST_GRANTED, index: head_eff.idx};
          mem_re   = 1'b1;
          pend_nxt = 1'b1;
        end else if (fresh_r < cap_eff) begin
          result    = '{status: ST_GRANTED, index: fresh_r[INDEX_W-1:0]};
          fresh_nxt = CAP_W'(fresh_r + 1'b1);
        end
      end else begin
        if ({1'b0, slot_index} < cap_eff) begin
          result   = '{status: ST_FREED, index: '0};
          mem_we   = 1'b1;
          head_nxt = '{empty: 1'b0, idx: slot_index};
        end else begin
          result = '{status: ST_BAD, index: '0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '{empty: 1'b1, idx: '1};
      fresh_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      fresh_r <= fresh_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign status = '{pop_pending: pend_r, fresh_count: fresh_r};

endmodule

[rtl/core/fsla_out_stage.sv]
module fsla_out_stage #(
  parameter int LINE_BYTES_LOG2 = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  fsla_pkg::result_t            result,
  input  logic [fsla_pkg::LINES_W-1:0] slot_lines,
  output logic                         ready_in,
  fsla_out_if.source                   out_ch
);
  import fsla_pkg::*;

  localparam int PROD_W = INDEX_W + LINES_W;
  localparam int FULL_W = (PROD_W + LINE_BYTES_LOG2 > OFFSET_W) ?
                          (PROD_W + LINE_BYTES_LOG2) : OFFSET_W;

  logic                valid_r;
  status_t             status_r;
  logic [INDEX_W-1:0]  index_r;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic [PROD_W-1:0]   prod;
  logic [FULL_W-1:0]   full;

  assign prod = PROD_W'(result.index) * PROD_W'(slot_lines);
  assign full = FULL_W'(prod) << LINE_BYTES_LOG2;
  assign offset_nxt = (result.status == ST_GRANTED) ? full[OFFSET_W-1:0] : '0;

  assign ready_in = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_in) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && ready_in) begin
      status_r <= result.status;
      index_r  <= result.index;
      offset_r <= offset_nxt;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.granted_index = index_r;
  assign out_ch.byte_offset   = offset_r;

endmodule

[rtl/core/fixed_slot_free_list_allocator_top.sv]
// Fixed-size slot allocator. Each input item is an allocate or a free, and each gives
// exactly one result item. The block takes one item per cycle whenever the result
// register is empty or being drained, so a result appears the cycle after its item is
// accepted. An allocate pops the head of a LIFO free chain whose links live in a
// single-port-write, registered-read link store; the next head is taken straight from
// that store's read register in the following cycle, which is what bounds the loop to
// one item per cycle. With an empty chain, never-used slots are handed out up to the
// capacity register (clamped to SLOTS), then the pool reports full. A free at or above
// capacity is reported as a bad index. byte_offset is index * slot_lines *
// 2**LINE_BYTES_LOG2, wrapped to 22 bits. The link store needs no clearing after reset.
module fixed_slot_free_list_allocator_top #(
  parameter int SLOTS           = 1024,
  parameter int LINE_BYTES_LOG2 = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fsla_in_if.sink                         in_ch,
  fsla_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [fsla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsla_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fsla_pkg::*;

  localparam int DEPTH = (SLOTS < 1024) ? SLOTS : 1024;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [CAP_W-1:0] SLOTS_CAP = CAP_W'(DEPTH);

  logic [CAP_W-1:0]   capacity_r;
  logic [LINES_W-1:0] slot_lines_r;
  logic               in_acc, stage_ready;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  link_t              mem_wdata, mem_rdata;
  result_t            result;
  core_status_t       core_st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r   <= CAP_RESET;
      slot_lines_r <= LINES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAPACITY:   capacity_r   <= cfg_wdata[CAP_W-1:0];
        CFG_SLOT_LINES: slot_lines_r <= cfg_wdata[LINES_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = stage_ready;
  assign in_acc      = in_ch.valid && stage_ready;

  fsla_alloc_core #(.SLOTS(SLOTS)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_acc),
    .kind       (in_ch.kind),
    .slot_index (in_ch.slot_index),
    .capacity   (capacity_r),
    .rd_data    (mem_rdata),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .result     (result),
    .status     (core_st)
  );

  fsla_link_mem #(.DEPTH(DEPTH), .AW(AW)) u_links (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  fsla_out_stage #(.LINE_BYTES_LOG2(LINE_BYTES_LOG2)) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_acc),
    .result     (result),
    .slot_lines (slot_lines_r),
    .ready_in   (stage_ready),
    .out_ch     (out_ch)
  );

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_ch.valid)
    else $error("accepted item produced no result item");

  a_zero_unless_granted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_GRANTED) |->
      (out_ch.granted_index == '0 && out_ch.byte_offset == '0))
    else $error("non-grant result carries an index or offset");

  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    core_st.fresh_count <= SLOTS_CAP)
    else $error("fresh slot count ran past the pool size");

  a_pop_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    core_st.pop_pending |-> $past(in_acc))
    else $error("chain pop pending without an accepted item");

endmodule

[test/fixed_slot_free_list_allocator_top_test.sv]
`timescale 1ns / 100ps

module fixed_slot_free_list_allocator_top_test;
  import fsla_pkg::*;

  localparam int POOL_SLOTS = 1024;
  localparam int LINE_LOG2 = 6;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 300;
  localparam logic [CAP_W-1:0] HEAD_EMPTY = '1;

  typedef struct {
    status_t               status;
    logic [INDEX_W-1:0]    index;
    logic [OFFSET_W-1:0]   offset;
  } reply_t;

  class slot_pool_model;
    logic [CAP_W-1:0]   cap_reg;
    logic [LINES_W-1:0] lines_reg;
    logic [CAP_W-1:0]   chain_head;
    logic [CAP_W-1:0]   fresh_next;
    logic [CAP_W-1:0]   link_mem [POOL_SLOTS];
    reply_t             owed_replies[$];
    int                 live_slots[$];
    int                 mismatches;

    function new();
      cap_reg = CAP_RESET;
      lines_reg = LINES_RESET;
      chain_head = HEAD_EMPTY;
      fresh_next = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] value);
      if (sel == CFG_CAPACITY) begin
        cap_reg = value;
      end else begin
        lines_reg = value[LINES_W-1:0];
      end
    endfunction

    function int pick_live();
      if (live_slots.size() == 0) begin
        return $urandom_range(POOL_SLOTS - 1);
      end
      return live_slots[$urandom_range(live_slots.size() - 1)];
    endfunction

    function void note_request(logic kind, logic [INDEX_W-1:0] idx);
      reply_t      r;
      int          limit;
      int          got;
      int unsigned bytes;
      limit = (cap_reg > POOL_SLOTS) ? POOL_SLOTS : int'(cap_reg);
      got = -1;
      r.status = ST_FULL;
      r.index = '0;
      r.offset = '0;
      if (kind == KIND_ALLOC) begin
        if (chain_head != HEAD_EMPTY) begin
          got = int'(chain_head);
          chain_head = link_mem[got];
        end else if (int'(fresh_next) < limit) begin
          got = int'(fresh_next);
          fresh_next = fresh_next + 1'b1;
        end
        if (got >= 0) begin
          bytes = (got * int'(lines_reg)) << LINE_LOG2;
          r.status = ST_GRANTED;
          r.index = INDEX_W'(got);
          r.offset = OFFSET_W'(bytes);
          live_slots.push_back(got);
        end
      end else if (int'(idx) < limit) begin
        link_mem[idx] = chain_head;
        chain_head = CAP_W'(idx);
        r.status = ST_FREED;
        for (int i = 0; i < live_slots.size(); i++) begin
          if (live_slots[i] == int'(idx)) begin
            live_slots.delete(i);
            i = live_slots.size();
          end
        end
      end else begin
        r.status = ST_BAD;
      end
      owed_replies.push_back(r);
    endfunction

    function void check_reply(status_t st, logic [INDEX_W-1:0] idx,
                              logic [OFFSET_W-1:0] off);
      reply_t r;
      if (owed_replies.size() == 0) begin
        if (mismatches < 10) begin
          $display("%0t: unexpected item status %0d index %0d offset %0d", $realtime,
                   st, idx, off);
        end
        mismatches++;
      end else begin
        r = owed_replies.pop_front();
        if (st !== r.status || idx !== r.index || off !== r.offset) begin
          if (mismatches < 10) begin
            $display("%0t: expected status %0d index %0d offset %0d, got %0d %0d %0d",
                     $realtime, r.status, r.index, r.offset, st, idx, off);
          end
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic hold_go;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int quiet_cycles;
  slot_pool_model pool = new();

  fsla_in_if in_ch();
  fsla_out_if out_ch();

  fixed_slot_free_list_allocator_top #(
    .SLOTS(POOL_SLOTS),
    .LINE_BYTES_LOG2(LINE_LOG2)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      pool.check_reply(out_ch.status, out_ch.granted_index, out_ch.byte_offset);
    end
    if (hold_go) begin
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("** fixed_slot_free_list_allocator_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drive_item(logic kind, logic [INDEX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.slot_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    pool.note_request(kind, idx);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(posedge clk);
    pool.set_reg(sel, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pool.owed_replies.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic alloc_item();
    drive_item(KIND_ALLOC, INDEX_W'($urandom_range(POOL_SLOTS - 1)));
  endtask

  task automatic directed_items();
    write_cfg(CFG_CAPACITY, 11'd4);
    write_cfg(CFG_SLOT_LINES, 11'd64);
    repeat (5) alloc_item();
    drive_item(KIND_FREE, 10'd1023);
    drive_item(KIND_FREE, 10'd4);
    drive_item(KIND_FREE, 10'd0);
    drive_item(KIND_FREE, 10'd3);
    repeat (3) alloc_item();
    drive_item(KIND_FREE, 10'd2);
    drive_item(KIND_FREE, 10'd2);
    repeat (3) alloc_item();
    settle();
    write_cfg(CFG_CAPACITY, 11'd0);
    write_cfg(CFG_SLOT_LINES, 11'd0);
    alloc_item();
    drive_item(KIND_FREE, 10'd0);
    settle();
    write_cfg(CFG_CAPACITY, 11'd2047);
    write_cfg(CFG_SLOT_LINES, 11'd127);
    alloc_item();
    drive_item(KIND_FREE, 10'd1023);
    alloc_item();
    settle();
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_capacity();
    case ($urandom_range(7))
      0: return 11'd1;
      1: return 11'd1024;
      2: return 11'd2047;
      3: return 11'd0;
      4: return CFG_DATA_W'($urandom_range(1023, 17));
      5: return CFG_DATA_W'($urandom_range(2047, 1025));
      default: return CFG_DATA_W'($urandom_range(16, 2));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_lines();
    case ($urandom_range(7))
      0: return 11'd1;
      1: return 11'd64;
      2: return 11'd0;
      3: return 11'd127;
      default: return CFG_DATA_W'($urandom_range(64, 1));
    endcase
  endfunction

  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      alloc_item();
    end else if (pick < 88) begin
      drive_item(KIND_FREE, INDEX_W'(pool.pick_live()));
    end else begin
      drive_item(KIND_FREE, INDEX_W'($urandom_range(POOL_SLOTS - 1)));
    end
  endtask

  task automatic run_phase(int items, int s_idle, int r_idle, bit squeeze);
    int done;
    int chunk;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    done = 0;
    while (done < items) begin
      settle();
      write_cfg(CFG_CAPACITY, pick_capacity());
      write_cfg(CFG_SLOT_LINES, pick_lines());
      if (squeeze && done == 0) begin
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      chunk = $urandom_range(160, 60);
      if (chunk > items - done) begin
        chunk = items - done;
      end
      repeat (chunk) random_item();
      done += chunk;
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    hold_go = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    send_idle_pct = 12;
    recv_idle_pct = 72;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_ALLOC;
    in_ch.slot_index = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items();
    run_phase(650, 12, 72, 1'b0);
    run_phase(650, 72, 12, 1'b1);
    run_phase(650, 0, 0, 1'b1);
    in_ch.valid <= 1'b0;
    while (pool.owed_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pool.mismatches == 0 && pool.owed_replies.size() == 0) begin
      $display("** fixed_slot_free_list_allocator_top: PASSED **");
    end else begin
      $display("** fixed_slot_free_list_allocator_top: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/fsla_pkg.sv
rtl/core/fsla_if.sv
rtl/core/fsla_link_mem.sv
rtl/core/fsla_alloc_core.sv
rtl/core/fsla_out_stage.sv
rtl/core/fixed_slot_free_list_allocator_top.sv
test/fixed_slot_free_list_allocator_top_test.sv
